FILE: sv/heightmap_triangle_sampler_defines.svh
// ----------------------------------------------------------------------------
// heightmap triangle sampler assertion macros
// shared assertion forms for the sampler rtl
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_TRIANGLE_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLER_DEFINES_SVH

// implication checked every clock edge outside reset
`define HTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// shared constants and types of the heightmap triangle sampler
// ----------------------------------------------------------------------------
package hts_pkg;
    localparam int GridCells   = 128;
    localparam int CellBits    = $clog2(GridCells);
    localparam int CornerSide  = GridCells + 1;
    localparam int CornerDepth = CornerSide * CornerSide;
    localparam int CentreDepth = GridCells * GridCells;
    localparam int CornerAw    = $clog2(CornerDepth);
    localparam int CentreAw    = $clog2(CentreDepth);

    localparam logic [1:0] KIND_CORNER = 2'd0;
    localparam logic [1:0] KIND_CENTRE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] REG_GRID_PRESENT  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_FORMAT = 3'd1;
    localparam logic [2:0] REG_BASE_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_HEIGHT_SCALE  = 3'd3;
    localparam logic [2:0] REG_WORLD_TO_GRID = 3'd4;

    localparam logic [1:0] FMT_FIXED = 2'd0;
    localparam logic [1:0] FMT_U16   = 2'd1;
    localparam logic [1:0] FMT_U8    = 2'd2;
    localparam logic [1:0] FMT_SPARE = 2'd3;
endpackage

FILE: sv/hts_ram.sv
// ----------------------------------------------------------------------------
// hts_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module hts_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: sv/heightmap_triangle_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler
// triangle interpolation over a corner grid and a cell-centre grid
// ----------------------------------------------------------------------------
// A write item sets busy high for one cycle after start. A query maps the
// cell and the fractions as start is taken; the four corner heights then
// come one after another from one corner ram port, the centre height from
// its own ram, then three registered stages follow: the triangle sum, the
// scale multiply, and the rounding and saturation. A query with no grid
// loaded answers base height on the height strobe in the cycle after start, with
// busy staying low. The result is shown for one cycle on height with
// result_valid and cannot be held off. Configuration is taken only while
// busy is low. Both grids are undefined until written.
module heightmap_triangle_sampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [14:0] entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] x_world,
    input  logic signed [31:0] y_world,
    output logic        result_valid,
    output logic signed [31:0] height,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hts_pkg::*;
    `include "heightmap_triangle_sampler_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_MAP, S_RD1, S_RD2, S_RD3, S_RD4, S_CALC, S_MUL, S_SCALE, S_OUT
    } state_t;

    state_t state_reg;
    logic grid_present_reg;
    logic [1:0] height_format_reg;
    logic [31:0] base_height_reg, height_scale_reg;
    logic [19:0] world_to_grid_reg;

    logic [1:0] kind_reg;
    logic [14:0] idx_reg;
    logic [31:0] val_reg;
    logic [CellBits-1:0] row_reg, col_reg;
    logic [13:0] fx_reg, fy_reg;
    logic signed [32:0] h1_reg, h2_reg, h3_reg, h4_reg;
    logic signed [33:0] h5_reg;
    logic signed [49:0] s_reg;
    logic signed [66:0] mhi_reg;
    logic signed [66:0] mlo_reg;
    logic signed [31:0] height_reg;
    logic result_valid_reg;

    assign cfg_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign height = height_reg;

    // grid position: 4096*2^34 - coord*scale, exact in 74 bits
    logic signed [52:0] prod_x, prod_y;
    logic signed [73:0] px, py;
    assign prod_x = x_world * $signed({1'b0, world_to_grid_reg});
    assign prod_y = y_world * $signed({1'b0, world_to_grid_reg});
    assign px = (74'sd1 <<< (34 + $clog2(32 * GridCells))) - 74'(prod_x);
    assign py = (74'sd1 <<< (34 + $clog2(32 * GridCells))) - 74'(prod_y);

    // corner and centre address sequencing
    logic [CornerAw-1:0] base_addr, c_addr;
    logic [CentreAw-1:0] e_addr;
    logic c_we, e_we;
    logic [31:0] c_rdata, e_rdata;
    assign base_addr = CornerAw'(row_reg) * CornerAw'(CornerSide) + CornerAw'(col_reg);

    always_comb
    begin
        c_addr = idx_reg[CornerAw-1:0];
        e_addr = {row_reg, col_reg};
        unique case (state_reg)
            S_MAP:   c_addr = base_addr;
            S_RD1:   c_addr = base_addr + CornerAw'(CornerSide);
            S_RD2:   c_addr = base_addr + CornerAw'(1);
            S_RD3:   c_addr = base_addr + CornerAw'(CornerSide + 1);
            default: c_addr = idx_reg[CornerAw-1:0];
        endcase
        if (state_reg == S_WRITE)
        begin
            e_addr = idx_reg[CentreAw-1:0];
        end
    end
    assign c_we = (state_reg == S_WRITE) && (kind_reg == KIND_CORNER)
                && (idx_reg < 15'(CornerDepth));
    assign e_we = (state_reg == S_WRITE) && (kind_reg == KIND_CENTRE)
                && (idx_reg < 15'(CentreDepth));

    hts_ram #(.Width(32), .Depth(CornerDepth)) u_corner (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(val_reg), .rdata(c_rdata)
    );
    hts_ram #(.Width(32), .Depth(CentreDepth)) u_centre (
        .clk(clk), .we(e_we), .addr(e_addr), .wdata(val_reg), .rdata(e_rdata)
    );

    function automatic logic signed [32:0] entry(input logic [31:0] raw, input logic [1:0] fmt);
        logic signed [32:0] v;
        if (fmt == FMT_FIXED)
            v = {raw[31], raw};
        else if (fmt == FMT_U8)
            v = {25'd0, raw[7:0]};
        else
            v = {17'd0, raw[15:0]};
        return v;
    endfunction

    // triangle coefficients
    logic signed [35:0] ca, cb, cc;
    logic signed [49:0] s_next;
    always_comb
    begin
        if ({1'b0, fx_reg} + {1'b0, fy_reg} < 15'd16384)
        begin
            if (fx_reg > fy_reg)
            begin
                ca = 36'(h2_reg - h1_reg);
                cb = 36'(h5_reg) - 36'(h1_reg) - 36'(h2_reg);
                cc = 36'(h1_reg);
            end
            else
            begin
                ca = 36'(h5_reg) - 36'(h1_reg) - 36'(h3_reg);
                cb = 36'(h3_reg - h1_reg);
                cc = 36'(h1_reg);
            end
        end
        else
        begin
            if (fx_reg > fy_reg)
            begin
                ca = 36'(h2_reg) + 36'(h4_reg) - 36'(h5_reg);
                cb = 36'(h4_reg - h2_reg);
                cc = 36'(h5_reg) - 36'(h4_reg);
            end
            else
            begin
                ca = 36'(h4_reg - h3_reg);
                cb = 36'(h3_reg) + 36'(h4_reg) - 36'(h5_reg);
                cc = 36'(h5_reg) - 36'(h4_reg);
            end
        end
        s_next = 50'(ca * $signed({1'b0, fx_reg})) + 50'(cb * $signed({1'b0, fy_reg}))
               + (50'(cc) <<< 14);
    end

    // final rounding and saturation
    logic signed [66:0] m_sum, q_val;
    logic signed [49:0] f_val;
    logic signed [31:0] h_next;
    always_comb
    begin
        m_sum = mhi_reg + (mlo_reg >>> 16);
        q_val = (m_sum >>> 2) + 67'(signed'(base_height_reg));
        f_val = s_reg >>> 14;
        if (height_format_reg == FMT_FIXED)
        begin
            if (f_val > 50'sd2147483647)
                h_next = 32'h7fffffff;
            else if (f_val < -50'sd2147483648)
                h_next = 32'h80000000;
            else
                h_next = f_val[31:0];
        end
        else
        begin
            if (q_val > 67'sd2147483647)
                h_next = 32'h7fffffff;
            else if (q_val < -67'sd2147483648)
                h_next = 32'h80000000;
            else
                h_next = q_val[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            result_valid_reg  <= 1'b0;
            grid_present_reg  <= 1'b0;
            height_format_reg <= FMT_FIXED;
            base_height_reg   <= 32'd0;
            height_scale_reg  <= 32'd65536;
            world_to_grid_reg <= 20'd251658;
            kind_reg          <= KIND_CORNER;
            idx_reg           <= '0;
            val_reg           <= '0;
            row_reg           <= '0;
            col_reg           <= '0;
            fx_reg            <= '0;
            fy_reg            <= '0;
            h1_reg            <= '0;
            h2_reg            <= '0;
            h3_reg            <= '0;
            h4_reg            <= '0;
            h5_reg            <= '0;
            s_reg             <= '0;
            mhi_reg           <= '0;
            mlo_reg           <= '0;
            height_reg        <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GRID_PRESENT:  grid_present_reg  <= cfg_data[0];
                    REG_HEIGHT_FORMAT: height_format_reg <= cfg_data[1:0];
                    REG_BASE_HEIGHT:   base_height_reg   <= cfg_data;
                    REG_HEIGHT_SCALE:  height_scale_reg  <= cfg_data;
                    REG_WORLD_TO_GRID: world_to_grid_reg <= cfg_data[19:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind;
                        idx_reg  <= entry_index;
                        val_reg  <= entry_value;
                        // cell and fraction of the query, masked to the grid
                        row_reg  <= px[34 +: CellBits];
                        col_reg  <= py[34 +: CellBits];
                        fx_reg   <= px[33:20];
                        fy_reg   <= py[33:20];
                        if (kind == KIND_QUERY)
                        begin
                            if (grid_present_reg)
                                state_reg <= S_MAP;
                            else
                            begin
                                height_reg       <= base_height_reg;
                                result_valid_reg <= 1'b1;
                                state_reg        <= S_IDLE;
                            end
                        end
                        else
                            state_reg <= S_WRITE;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_MAP:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    h1_reg    <= entry(c_rdata, height_format_reg);
                    h5_reg    <= 34'(entry(e_rdata, height_format_reg)) <<< 1;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    h2_reg    <= entry(c_rdata, height_format_reg);
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    h3_reg    <= entry(c_rdata, height_format_reg);
                    state_reg <= S_RD4;
                end
                S_RD4:
                begin
                    h4_reg    <= entry(c_rdata, height_format_reg);
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    s_reg     <= s_next;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    mhi_reg   <= 67'(s_reg * $signed({1'b0, height_scale_reg[31:16]}));
                    mlo_reg   <= 67'(s_reg * $signed({1'b0, height_scale_reg[15:0]}));
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    height_reg       <= h_next;
                    result_valid_reg <= 1'b1;
                    state_reg        <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `HTS_ASSERT_NXT(a_write_short, state_reg == S_WRITE, state_reg == S_IDLE)
    `HTS_ASSERT_IMP(a_no_start_busy, result_valid_reg && state_reg != S_IDLE, 1'b0)
    `HTS_ASSERT_IMP(a_we_excl, c_we, !e_we)
    `HTS_ASSERT_IMP(a_cfg_idle, cfg_valid && cfg_ready, state_reg == S_IDLE)
endmodule
